[hdl/gdad_pkg.sv]
package gdad_pkg;

  // field widths
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YIN_W  = 14;
  localparam int ADD_W  = 20;
  // internal year, wide enough for start year plus the largest day count
  localparam int YEAR_W = 16;
  // year modulo 400
  localparam int YMOD_W = 9;
  // day remainder: day of year plus day count
  localparam int REM_W  = 21;

  // restoring reduction of the start year modulo 400, one multiple per step
  localparam int MOD_STEPS = 6;
  localparam int SHIFT_W   = 3;

  localparam int unsigned CYCLE_DAYS = 146097;

  localparam logic [MON_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MON_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MON_W-1:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0] start_day;
    logic [MON_W-1:0] start_month;
    logic [YIN_W-1:0] start_year;
    logic [ADD_W-1:0] days_to_add;
  } in_t;

  typedef struct packed {
    logic [DAY_W-1:0] result_day;
    logic [MON_W-1:0] result_month;
    logic [YIN_W-1:0] result_year;
    logic             date_valid;
    logic             year_overflow;
  } out_t;

  typedef struct packed {
    logic               load;
    logic               mod_step;
    logic [SHIFT_W-1:0] mod_shift;
    logic               roll;
    logic               doy;
    logic               skip400;
    logic               skip100;
    logic               skip4;
    logic               skip1;
    logic               skipmon;
    logic               emit;
  } cmd_t;

  typedef struct packed {
    logic in_ok;
    logic ge400;
    logic ge100;
    logic ge4;
    logic ge1;
    logic mon_more;
  } sts_t;

  // leap year from the year modulo 400
  function automatic logic is_leap(input logic [YMOD_W-1:0] ym);
    return (ym[1:0] == 2'b00) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic lp, input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = lp ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // days in a common year before the first of month m
  function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

[hdl/gregorian_date_add_days_unit.sv]
// gregorian date adder: start date plus a day count gives the date that many days later
// input channel: in_valid_i / in_stall_o / in_data_i, a transfer when valid is high and
//   stall is low; the unit works on one date at a time and stalls the input while busy
// output channel: out_valid_o / out_stall_i / out_data_o, one result per input transfer,
//   held in an output register until the downstream side takes it
// a malformed start date (day 0, month outside 1..12) comes back unchanged with
//   date_valid low
// valid dates: year mod 400 by six restoring steps, month-end rollover, day of year,
//   then the remainder is walked down in 400-, 100-, 4- and 1-year strides and month
//   by month, each with its own compare, one stride per cycle
// the result is offered in the cycle the unit returns to idle, so the next input
//   transfer can come in that cycle
// while the receiver stalls, a finished result waits in the unit and the next date is
//   still taken and computed; it is held back only until the output register frees up
// reset clears the controller and the output valid; no clearing pass is needed
// MAX_YEAR sets the saturation point, DAY_COUNT_BITS the used low bits of days_to_add
module gregorian_date_add_days_unit #(
  parameter int MAX_YEAR       = 9999,
  parameter int DAY_COUNT_BITS = 20
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gdad_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gdad_pkg::out_t out_data_o
);

  // command and status between the controller and the datapath
  gdad_pkg::cmd_t cmd;
  gdad_pkg::sts_t sts;

  gdad_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gdad_dpath #(
    .MAX_YEAR       (MAX_YEAR),
    .DAY_COUNT_BITS (DAY_COUNT_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  // a transfer always makes the unit busy for at least the next cycle
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after transfer");

  // overflow only ever flagged on a valid start date
  a_overflow_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.year_overflow |-> out_data_o.date_valid)
    else $error("overflow on invalid date");

  // a computed date has a real month and day
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.date_valid |->
      out_data_o.result_day != 5'd0 && out_data_o.result_month != 4'd0 &&
      out_data_o.result_month <= gdad_pkg::MONTH_DEC)
    else $error("result date out of range");
`endif

endmodule

[hdl/gdad_ctrl.sv]
module gdad_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  gdad_pkg::sts_t  sts_i,
  output gdad_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MOD  = 4'd1;
  localparam logic [3:0] S_ROLL = 4'd2;
  localparam logic [3:0] S_DOY  = 4'd3;
  localparam logic [3:0] S_Y400 = 4'd4;
  localparam logic [3:0] S_Y100 = 4'd5;
  localparam logic [3:0] S_Y4   = 4'd6;
  localparam logic [3:0] S_Y1   = 4'd7;
  localparam logic [3:0] S_MON  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]                   state_q, state_d;
  logic [gdad_pkg::SHIFT_W-1:0] cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = gdad_pkg::SHIFT_W'(gdad_pkg::MOD_STEPS - 1);
          state_d    = sts_i.in_ok ? S_MOD : S_DONE;
        end
      end
      S_MOD: begin
        cmd_o.mod_step  = 1'b1;
        cmd_o.mod_shift = cnt_q;
        if (cnt_q == '0) begin
          state_d = S_ROLL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_ROLL: begin
        cmd_o.roll = 1'b1;
        state_d    = S_DOY;
      end
      S_DOY: begin
        cmd_o.doy = 1'b1;
        state_d   = S_Y400;
      end
      S_Y400: begin
        if (sts_i.ge400) cmd_o.skip400 = 1'b1;
        else state_d = S_Y100;
      end
      S_Y100: begin
        if (sts_i.ge100) cmd_o.skip100 = 1'b1;
        else state_d = S_Y4;
      end
      S_Y4: begin
        if (sts_i.ge4) cmd_o.skip4 = 1'b1;
        else state_d = S_Y1;
      end
      S_Y1: begin
        if (sts_i.ge1) cmd_o.skip1 = 1'b1;
        else state_d = S_MON;
      end
      S_MON: begin
        if (sts_i.mon_more) cmd_o.skipmon = 1'b1;
        else state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hdl/gdad_dpath.sv]
module gdad_dpath #(
  parameter int MAX_YEAR       = 9999,
  parameter int DAY_COUNT_BITS = 20
) (
  input  logic           clk_i,
  input  gdad_pkg::in_t  in_data_i,
  input  gdad_pkg::cmd_t cmd_i,
  output gdad_pkg::sts_t sts_o,
  output gdad_pkg::out_t out_data_o
);

  localparam int KEEP = (DAY_COUNT_BITS < gdad_pkg::ADD_W) ? DAY_COUNT_BITS : gdad_pkg::ADD_W;
  localparam logic [gdad_pkg::ADD_W-1:0] ADD_MASK =
    {gdad_pkg::ADD_W{1'b1}} >> (gdad_pkg::ADD_W - KEEP);
  localparam logic [gdad_pkg::YEAR_W-1:0] MAX_Y   = MAX_YEAR[gdad_pkg::YEAR_W-1:0];
  localparam logic [gdad_pkg::YIN_W-1:0]  SAT_Y   = MAX_YEAR[gdad_pkg::YIN_W-1:0];
  localparam logic [gdad_pkg::REM_W-1:0]  CYCLE_R = gdad_pkg::CYCLE_DAYS[gdad_pkg::REM_W-1:0];

  logic [gdad_pkg::DAY_W-1:0]  day_q;
  logic [gdad_pkg::MON_W-1:0]  mon_q;
  logic [gdad_pkg::YEAR_W-1:0] year_q;
  logic [gdad_pkg::YIN_W-1:0]  modw_q;
  logic [gdad_pkg::YMOD_W-1:0] ym_q;
  logic [gdad_pkg::ADD_W-1:0]  add_q;
  logic [gdad_pkg::REM_W-1:0]  rem_q;
  logic                        ok_q;
  gdad_pkg::out_t              out_q, out_d;

  logic [gdad_pkg::YIN_W:0]    mod_dec, mod_diff;
  logic                        leap_w, leap_y, roll_need;
  logic [gdad_pkg::DAY_W-1:0]  roll_len, mlen;
  logic [gdad_pkg::YMOD_W-1:0] ym_roll;
  logic [1:0]                  off4;
  logic [gdad_pkg::YMOD_W:0]   ka;
  logic                        cent;
  logic [gdad_pkg::REM_W-1:0]  len100, len4, len1, doy_sum;

  // advance a year modulo 400 by a step below 400
  function automatic logic [gdad_pkg::YMOD_W-1:0] inc_mod400(
    input logic [gdad_pkg::YMOD_W-1:0] ym,
    input logic [gdad_pkg::YMOD_W-1:0] step
  );
    logic [gdad_pkg::YMOD_W:0] s;
    s = {1'b0, ym} + {1'b0, step};
    if (s >= 10'd400) s = s - 10'd400;
    return s[gdad_pkg::YMOD_W-1:0];
  endfunction

  assign mod_dec  = 15'd400 << cmd_i.mod_shift;
  assign mod_diff = {1'b0, modw_q} - mod_dec;

  assign leap_w    = gdad_pkg::is_leap(modw_q[gdad_pkg::YMOD_W-1:0]);
  assign roll_len  = gdad_pkg::month_len(leap_w, mon_q);
  assign roll_need = day_q > roll_len;
  assign ym_roll   = (roll_need && mon_q == gdad_pkg::MONTH_DEC)
                   ? inc_mod400(modw_q[gdad_pkg::YMOD_W-1:0], 9'd1)
                   : modw_q[gdad_pkg::YMOD_W-1:0];

  assign leap_y = gdad_pkg::is_leap(ym_q);
  assign mlen   = gdad_pkg::month_len(leap_y, mon_q);

  // a hundred-year span holds a non-leap century unless it starts at year 0 or after year 300 mod 400
  assign len100 = (ym_q == '0 || ym_q > 9'd300) ? 21'd36525 : 21'd36524;

  // the one multiple of four in a four-year span
  assign off4 = 2'b00 - ym_q[1:0];
  assign ka   = {1'b0, ym_q} + {8'b0, off4};
  assign cent = (ka == 10'd100) || (ka == 10'd200) || (ka == 10'd300);
  assign len4 = cent ? 21'd1460 : 21'd1461;
  assign len1 = leap_y ? 21'd366 : 21'd365;

  assign doy_sum = gdad_pkg::REM_W'(gdad_pkg::days_before_month(mon_q))
                 + gdad_pkg::REM_W'(mon_q > gdad_pkg::MONTH_FEB && leap_y)
                 + gdad_pkg::REM_W'(day_q) - 21'd1
                 + gdad_pkg::REM_W'(add_q);

  assign sts_o.in_ok    = (in_data_i.start_day != '0) && (in_data_i.start_month != '0)
                       && (in_data_i.start_month <= gdad_pkg::MONTH_DEC);
  assign sts_o.ge400    = rem_q >= CYCLE_R;
  assign sts_o.ge100    = rem_q >= len100;
  assign sts_o.ge4      = rem_q >= len4;
  assign sts_o.ge1      = rem_q >= len1;
  assign sts_o.mon_more = (mon_q != gdad_pkg::MONTH_DEC)
                       && (rem_q >= gdad_pkg::REM_W'(mlen));

  always_comb begin
    if (!ok_q) begin
      out_d.result_day    = day_q;
      out_d.result_month  = mon_q;
      out_d.result_year   = year_q[gdad_pkg::YIN_W-1:0];
      out_d.date_valid    = 1'b0;
      out_d.year_overflow = 1'b0;
    end else if (year_q > MAX_Y) begin
      out_d.result_day    = 5'd31;
      out_d.result_month  = gdad_pkg::MONTH_DEC;
      out_d.result_year   = SAT_Y;
      out_d.date_valid    = 1'b1;
      out_d.year_overflow = 1'b1;
    end else begin
      out_d.result_day    = rem_q[gdad_pkg::DAY_W-1:0] + 5'd1;
      out_d.result_month  = mon_q;
      out_d.result_year   = year_q[gdad_pkg::YIN_W-1:0];
      out_d.date_valid    = 1'b1;
      out_d.year_overflow = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      day_q  <= in_data_i.start_day;
      mon_q  <= in_data_i.start_month;
      year_q <= gdad_pkg::YEAR_W'(in_data_i.start_year);
      modw_q <= in_data_i.start_year;
      add_q  <= in_data_i.days_to_add & ADD_MASK;
      ok_q   <= sts_o.in_ok;
    end else if (cmd_i.mod_step) begin
      if (!mod_diff[gdad_pkg::YIN_W]) modw_q <= mod_diff[gdad_pkg::YIN_W-1:0];
    end else if (cmd_i.roll) begin
      ym_q <= ym_roll;
      if (roll_need) begin
        day_q <= day_q - roll_len;
        if (mon_q == gdad_pkg::MONTH_DEC) begin
          mon_q  <= gdad_pkg::MONTH_JAN;
          year_q <= year_q + 16'd1;
        end else begin
          mon_q <= mon_q + 4'd1;
        end
      end
    end else if (cmd_i.doy) begin
      rem_q <= doy_sum;
      mon_q <= gdad_pkg::MONTH_JAN;
    end else if (cmd_i.skip400) begin
      rem_q  <= rem_q - CYCLE_R;
      year_q <= year_q + 16'd400;
    end else if (cmd_i.skip100) begin
      rem_q  <= rem_q - len100;
      year_q <= year_q + 16'd100;
      ym_q   <= inc_mod400(ym_q, 9'd100);
    end else if (cmd_i.skip4) begin
      rem_q  <= rem_q - len4;
      year_q <= year_q + 16'd4;
      ym_q   <= inc_mod400(ym_q, 9'd4);
    end else if (cmd_i.skip1) begin
      rem_q  <= rem_q - len1;
      year_q <= year_q + 16'd1;
      ym_q   <= inc_mod400(ym_q, 9'd1);
    end else if (cmd_i.skipmon) begin
      rem_q <= rem_q - gdad_pkg::REM_W'(mlen);
      mon_q <= mon_q + 4'd1;
    end
    if (cmd_i.emit) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule
